// ===== hw/rtl/hcbp_pkg.sv =====
// Shared constants and types for the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    // Field widths
    localparam int KIND_W = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // Longest code accepted; longer lengths saturate
    localparam int MAX_CODE_LEN = 32;
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        (MAX_CODE_LEN < CODE_W) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(CODE_W);

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_RAW    = 2'd2,
        KIND_FLUSH  = 2'd3
    } kind_t;

    // Saturate a code length to the supported maximum
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_LIMIT) ? LEN_LIMIT : len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hcbp_cmd_if.sv =====
// Valid/ready channel interfaces: command items in, packed bytes out.
`timescale 1ns / 1ps
`default_nettype none

interface hcbp_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [hcbp_pkg::KIND_W-1:0] kind;
    logic [hcbp_pkg::SYM_W-1:0]  symbol;
    logic [hcbp_pkg::CODE_W-1:0] code_value;
    logic [hcbp_pkg::LEN_W-1:0]  code_length;

    modport source (output valid, kind, symbol, code_value, code_length, input ready);
    modport sink   (input valid, kind, symbol, code_value, code_length, output ready);
endinterface

interface hcbp_byte_if;
    logic                        valid;
    logic                        ready;
    logic [hcbp_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Top level of the Huffman code bit packer: code table, bit packing, byte queue.
`timescale 1ns / 1ps
`default_nettype none

// Huffman code bit packer. Load items store a symbol's code and length in a
// 256-entry table; encode items look the code up and append it MSB-first to
// the pending byte; raw items append their own bits; flush emits a partial
// byte padded with zeros. One item is accepted per cycle unless the packing
// stage holds its item. An item is registered in the table-read register,
// where it is packed, and its bytes then enter the output queue, from whose
// head the first byte is offered. Each item yields 0 to 4 bytes, delivered
// one per cycle, while the sink is ready, from a 4-byte output queue; the
// packing stage holds an item that yields bytes until that queue is empty or
// draining its last byte, so the sustained rate is one item per cycle when
// bytes are sparse and one byte per cycle when output is the bottleneck. The
// length table is cleared at reset through per-entry valid bits; no clearing
// pass.
module huffman_code_bit_packer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hcbp_cmd_if.sink        cmd,
    hcbp_byte_if.source     stream
);

    localparam int DEPTH     = 1 << hcbp_pkg::SYM_W;
    localparam int MAX_BYTES = hcbp_pkg::CODE_W / hcbp_pkg::BYTE_W;
    localparam int ACC_W     = hcbp_pkg::CODE_W + hcbp_pkg::BYTE_W;

    // Code tables
    logic [hcbp_pkg::CODE_W-1:0] code_bits_mem [DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]  code_len_mem  [DEPTH];
    logic [DEPTH-1:0]            len_valid_reg;

    // Packing stage registers
    logic                        s1_valid_reg;
    hcbp_pkg::kind_t             s1_kind_reg;
    logic [hcbp_pkg::CODE_W-1:0] s1_value_reg;
    logic [hcbp_pkg::LEN_W-1:0]  s1_len_reg;
    logic [hcbp_pkg::CODE_W-1:0] s1_bits_rd_reg;
    logic [hcbp_pkg::LEN_W-1:0]  s1_len_rd_reg;
    logic                        s1_len_ok_reg;

    // Bit packing state
    logic [hcbp_pkg::BYTE_W-1:0] pending_reg;
    logic [2:0]                  bitpos_reg;

    // Output byte queue
    logic [hcbp_pkg::BYTE_W-1:0] obuf_reg [MAX_BYTES];
    logic [2:0]                  ocnt_reg;

    logic                        accept;
    hcbp_pkg::kind_t             in_kind;
    logic [hcbp_pkg::LEN_W-1:0]  in_len;
    logic [hcbp_pkg::CODE_W-1:0] s1_bits;
    logic [hcbp_pkg::LEN_W-1:0]  s1_len;
    logic [hcbp_pkg::CODE_W-1:0] aligned;
    logic [ACC_W-1:0]            acc;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [2:0]                  s1_nbytes;
    logic [hcbp_pkg::BYTE_W-1:0] s1_bytes [MAX_BYTES];
    logic [hcbp_pkg::BYTE_W-1:0] pending_next;
    logic [2:0]                  bitpos_next;
    logic                        s1_update;
    logic                        pop;
    logic                        obuf_free;
    logic                        s1_fire;

    assign accept  = cmd.valid && cmd.ready;
    assign in_kind = hcbp_pkg::kind_t'(cmd.kind);
    assign in_len  = hcbp_pkg::clamp_len(cmd.code_length);

    // Table write on load, registered read on every accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_kind == hcbp_pkg::KIND_LOAD)
            begin
                code_bits_mem[cmd.symbol] <= cmd.code_value;
                code_len_mem[cmd.symbol]  <= in_len;
            end
            s1_bits_rd_reg <= code_bits_mem[cmd.symbol];
            s1_len_rd_reg  <= code_len_mem[cmd.symbol];
            s1_kind_reg    <= in_kind;
            s1_value_reg   <= cmd.code_value;
            s1_len_reg     <= in_len;
        end
    end

    // Length valid bits: an unloaded symbol reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
            s1_len_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_len_ok_reg <= len_valid_reg[cmd.symbol];
            if (in_kind == hcbp_pkg::KIND_LOAD)
            begin
                len_valid_reg[cmd.symbol] <= 1'b1;
            end
        end
    end

    // Source of the bits to append
    always_comb
    begin
        s1_bits = '0;
        s1_len  = '0;
        case (s1_kind_reg)
            hcbp_pkg::KIND_ENCODE:
            begin
                s1_bits = s1_bits_rd_reg;
                s1_len  = s1_len_ok_reg ? s1_len_rd_reg : '0;
            end
            hcbp_pkg::KIND_RAW:
            begin
                s1_bits = s1_value_reg;
                s1_len  = s1_len_reg;
            end
            default:
            begin
                s1_bits = '0;
                s1_len  = '0;
            end
        endcase
    end

    // Left-align the code and merge it behind the pending bits
    assign aligned = s1_bits << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - s1_len);
    assign acc     = {pending_reg, {hcbp_pkg::CODE_W{1'b0}}}
                   | ({aligned, {hcbp_pkg::BYTE_W{1'b0}}} >> bitpos_reg);
    assign total   = hcbp_pkg::LEN_W'(bitpos_reg) + s1_len;

    // Bytes completed by this item and the leftover partial byte
    always_comb
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            s1_bytes[i] = acc[ACC_W-1-hcbp_pkg::BYTE_W*i -: hcbp_pkg::BYTE_W];
        end
        s1_nbytes    = '0;
        pending_next = pending_reg;
        bitpos_next  = bitpos_reg;
        case (s1_kind_reg) inside
            hcbp_pkg::KIND_FLUSH:
            begin
                s1_bytes[0]  = pending_reg;
                s1_nbytes    = (bitpos_reg != 3'd0) ? 3'd1 : 3'd0;
                pending_next = '0;
                bitpos_next  = '0;
            end
            hcbp_pkg::KIND_ENCODE, hcbp_pkg::KIND_RAW:
            begin
                s1_nbytes   = total[hcbp_pkg::LEN_W-1:3];
                bitpos_next = total[2:0];
                case (s1_nbytes)
                    3'd0:    pending_next = acc[ACC_W-1 -: hcbp_pkg::BYTE_W];
                    3'd1:    pending_next = acc[ACC_W-9 -: hcbp_pkg::BYTE_W];
                    3'd2:    pending_next = acc[ACC_W-17 -: hcbp_pkg::BYTE_W];
                    3'd3:    pending_next = acc[ACC_W-25 -: hcbp_pkg::BYTE_W];
                    default: pending_next = acc[hcbp_pkg::BYTE_W-1:0];
                endcase
            end
            default:
            begin
                s1_nbytes = '0;
            end
        endcase
    end

    // Stage handshake: the queue takes a new group only once empty or emptying
    assign pop       = stream.valid && stream.ready;
    assign obuf_free = (ocnt_reg == 3'd0) || ((ocnt_reg == 3'd1) && stream.ready);
    assign s1_fire   = s1_valid_reg && ((s1_nbytes == 3'd0) || obuf_free);
    assign s1_update = s1_fire && (s1_nbytes != 3'd0);
    assign cmd.ready = !s1_valid_reg || s1_fire;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pending_reg  <= '0;
            bitpos_reg   <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                pending_reg <= pending_next;
                bitpos_reg  <= bitpos_next;
            end
            if (s1_update)
            begin
                ocnt_reg <= s1_nbytes;
            end
            else if (pop)
            begin
                ocnt_reg <= ocnt_reg - 3'd1;
            end
        end
    end

    // Output queue payload: load a group or shift one byte out
    always_ff @(posedge clk)
    begin
        if (s1_update)
        begin
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                obuf_reg[i] <= s1_bytes[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_BYTES - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
        end
    end

    assign stream.valid       = (ocnt_reg != 3'd0);
    assign stream.out_byte    = obuf_reg[0];
    assign stream.last_of_run = (ocnt_reg == 3'd1);

    // Queue never holds more than one item's bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 3'(MAX_BYTES))
    else $error("byte queue count out of range");

    // Pending bits past the fill position stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & (8'hFF >> bitpos_reg)) == 8'h00)
    else $error("stray bits in pending byte");

    // A queued group drains one byte at a time and is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (ocnt_reg > 3'd1) |=>
            (ocnt_reg == $past(ocnt_reg)) || (ocnt_reg == $past(ocnt_reg) - 3'd1))
    else $error("byte queue overwritten before drained");

endmodule

`default_nettype wire
